[rtl/vst_pkg.sv]
// vst_pkg: shared types and codes of the volume/server table.
// Used by the channel interfaces and the table unit; depends on nothing.
package vst_pkg;

    localparam int unsigned VST_TABLE_DEPTH = 16;
    localparam int unsigned VST_SLOT_W      = 4;

    // opcodes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_MOUNTED  = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] vol_key;
        logic [31:0] root_obj;
        logic [63:0] srv_key;
        logic        still_mounted;
    } t_req;

    typedef struct packed {
        logic [2:0]            status;
        logic [63:0]           found_server;
        logic [31:0]           found_object;
        logic [VST_SLOT_W-1:0] slot_index;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

[rtl/vst_if.sv]
// vst_if: valid/ready channels carrying request and response items.
// Depends on vst_pkg for the payload structs.
interface vst_req_if;
    import vst_pkg::*;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vst_rsp_if;
    import vst_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/volume_server_table_unit.sv]
// volume_server_table_unit: associative volume -> (root object, server) table.
// Depends on vst_pkg and the channel interfaces in vst_if.sv.
//
//  channel | dir | payload                                            | handshake
//  i_req   | in  | opcode, vol_key, root_obj, srv_key, still_mounted  | valid/ready
//  o_rsp   | out | status, found_server, found_object, slot_index     | valid/ready
//
// One slot is read per cycle through the single registered read port of the
// entry memory and compared against the key by one 32-bit comparator.
// A hit ends the scan at the matching slot; a miss (and every insert of a new
// volume) reads all TABLE_DEPTH slots before the result is formed.
// Reset clears the valid bits at once; no clearing pass is needed.
// The result register holds a result until taken; a new item is taken as soon
// as the unit is idle, and a finished scan waits while the previous result is unread.
module volume_server_table_unit #(
    parameter int unsigned TABLE_DEPTH = vst_pkg::VST_TABLE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vst_req_if.sink    i_req,
    vst_rsp_if.source  o_rsp
);
    import vst_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    // entry memory
    logic [31:0] r_mem_volume [TABLE_DEPTH];
    logic [31:0] r_mem_object [TABLE_DEPTH];
    logic [63:0] r_mem_server [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;

    t_state      r_state, n_state;

    // latched request
    logic [1:0]  r_op;
    logic [31:0] r_vol;
    logic [31:0] r_obj;
    logic [63:0] r_srv;
    logic        r_mounted;

    // scan pipeline
    logic [AW-1:0] r_addr;
    logic          r_issue_live;
    logic [AW-1:0] r_cmp_idx;
    logic          r_cmp_live;
    logic          r_cmp_vbit;
    logic [31:0]   r_rd_vol;
    logic [31:0]   r_rd_obj;
    logic [63:0]   r_rd_srv;

    logic          r_free_found;
    logic [AW-1:0] r_free_idx;
    logic          r_match_found;
    logic [AW-1:0] r_match_idx;

    logic r_out_valid;
    t_rsp r_out;

    logic accept;
    logic hit;
    logic rd_en;
    logic out_free;
    logic finish;
    logic do_write;
    logic do_clear;
    t_rsp n_out;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // sequencer and result decode
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        hit         = 1'b0;
        rd_en       = 1'b0;
        finish      = 1'b0;
        do_write    = 1'b0;
        do_clear    = 1'b0;
        n_out       = '0;
        n_out.status = ST_NOTFOUND;

        case (r_op)
            OP_INSERT: begin
                if (r_match_found) begin
                    n_out.status     = ST_DUP;
                    n_out.slot_index = VST_SLOT_W'(r_match_idx);
                end else if (r_free_found) begin
                    n_out.status     = ST_OK;
                    n_out.slot_index = VST_SLOT_W'(r_free_idx);
                    do_write         = 1'b1;
                end else begin
                    n_out.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (r_match_found) begin
                    n_out.slot_index = VST_SLOT_W'(r_match_idx);
                    if (r_rd_srv != r_srv) begin
                        n_out.status = ST_MISMATCH;
                    end else if (r_mounted) begin
                        n_out.status = ST_MOUNTED;
                    end else begin
                        n_out.status = ST_OK;
                        do_clear     = 1'b1;
                    end
                end
            end
            OP_LOOKUP: begin
                if (r_match_found) begin
                    n_out.status       = ST_OK;
                    n_out.found_server = r_rd_srv;
                    n_out.found_object = r_rd_obj;
                    n_out.slot_index   = VST_SLOT_W'(r_match_idx);
                end
            end
            default: begin
            end
        endcase

        case (r_state)
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                hit   = r_cmp_live && r_cmp_vbit && (r_rd_vol == r_vol);
                // hold the read data of a hit for the finish step
                rd_en = r_issue_live && !hit;
                if (hit || (r_cmp_live && r_cmp_idx == LAST)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (!finish) begin
            do_write = 1'b0;
            do_clear = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_req.data.opcode;
            r_vol     <= i_req.data.vol_key;
            r_obj     <= i_req.data.root_obj;
            r_srv     <= i_req.data.srv_key;
            r_mounted <= i_req.data.still_mounted;
        end
    end

    // scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_live  <= 1'b0;
            r_cmp_live    <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_found <= 1'b0;
        end else if (accept) begin
            r_issue_live  <= 1'b1;
            r_cmp_live    <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_found <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_cmp_live <= rd_en;
            if (rd_en && r_addr == LAST) begin
                r_issue_live <= 1'b0;
            end
            if (rd_en && !r_valid[r_addr] && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (hit) begin
                r_match_found <= 1'b1;
                r_issue_live  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr     <= r_addr + AW'(1);
            r_cmp_idx  <= r_addr;
            r_cmp_vbit <= r_valid[r_addr];
            if (!r_valid[r_addr] && !r_free_found) begin
                r_free_idx <= r_addr;
            end
        end
        if (hit) begin
            r_match_idx <= r_cmp_idx;
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem_volume[r_free_idx] <= r_vol;
            r_mem_object[r_free_idx] <= r_obj;
            r_mem_server[r_free_idx] <= r_srv;
        end
        if (rd_en) begin
            r_rd_vol <= r_mem_volume[r_addr];
            r_rd_obj <= r_mem_object[r_addr];
            r_rd_srv <= r_mem_server[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (do_write) begin
            r_valid[r_free_idx] <= 1'b1;
        end else if (do_clear) begin
            r_valid[r_match_idx] <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_valid_only_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(finish) |-> $stable(r_valid))
        else $error("valid bits changed outside the finish step");

    a_insert_adds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_write |=> $countones(r_valid) == $past($countones(r_valid)) + 1)
        else $error("insert did not occupy exactly one free slot");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish && n_out.status == ST_FULL |-> &r_valid)
        else $error("table full reported with a free slot");

    a_match_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH && r_match_found |-> r_valid[r_match_idx])
        else $error("matched slot is not valid");
`endif

endmodule

[sim/volume_server_table_unit_tb.sv]
// Testbench for volume_server_table_unit: random and directed insert, remove and
// lookup items, checked against a shadow copy of the table held in a scoreboard class.
// Depends on vst_pkg, the channel interfaces in vst_if.sv and the table unit.

class table_shadow;
    bit             in_use[vst_pkg::VST_TABLE_DEPTH];
    logic [31:0]    volume_of[vst_pkg::VST_TABLE_DEPTH];
    logic [31:0]    object_of[vst_pkg::VST_TABLE_DEPTH];
    logic [63:0]    server_of[vst_pkg::VST_TABLE_DEPTH];
    vst_pkg::t_rsp  pending_rsp[$];
    int unsigned    errors;

    function new();
        foreach (in_use[i]) in_use[i] = 1'b0;
        errors = 0;
    endfunction

    function int find_volume(logic [31:0] vol);
        foreach (in_use[i]) begin
            if (in_use[i] && volume_of[i] == vol) return i;
        end
        return -1;
    endfunction

    function int find_free();
        foreach (in_use[i]) begin
            if (!in_use[i]) return i;
        end
        return -1;
    endfunction

    function int unsigned outstanding();
        return pending_rsp.size();
    endfunction

    // Stimulus helper: server currently stored for a volume, if any.
    function bit stored_server(logic [31:0] vol, output logic [63:0] srv);
        int m;
        m = find_volume(vol);
        srv = '0;
        if (m < 0) return 1'b0;
        srv = server_of[m];
        return 1'b1;
    endfunction

    // Apply one accepted request to the shadow and queue its expected result.
    function void take_request(vst_pkg::t_req req);
        vst_pkg::t_rsp rsp;
        int            m;
        rsp        = '0;
        rsp.status = vst_pkg::ST_NOTFOUND;
        m          = find_volume(req.vol_key);
        case (req.opcode)
            vst_pkg::OP_INSERT: begin
                if (m >= 0) begin
                    rsp.status     = vst_pkg::ST_DUP;
                    rsp.slot_index = m[vst_pkg::VST_SLOT_W-1:0];
                end else begin
                    m = find_free();
                    if (m < 0) begin
                        rsp.status = vst_pkg::ST_FULL;
                    end else begin
                        in_use[m]      = 1'b1;
                        volume_of[m]   = req.vol_key;
                        object_of[m]   = req.root_obj;
                        server_of[m]   = req.srv_key;
                        rsp.status     = vst_pkg::ST_OK;
                        rsp.slot_index = m[vst_pkg::VST_SLOT_W-1:0];
                    end
                end
            end
            vst_pkg::OP_REMOVE: begin
                if (m >= 0) begin
                    rsp.slot_index = m[vst_pkg::VST_SLOT_W-1:0];
                    // server check takes priority over the mount check
                    if (server_of[m] != req.srv_key) begin
                        rsp.status = vst_pkg::ST_MISMATCH;
                    end else if (req.still_mounted) begin
                        rsp.status = vst_pkg::ST_MOUNTED;
                    end else begin
                        in_use[m]  = 1'b0;
                        rsp.status = vst_pkg::ST_OK;
                    end
                end
            end
            vst_pkg::OP_LOOKUP: begin
                if (m >= 0) begin
                    rsp.status       = vst_pkg::ST_OK;
                    rsp.found_server = server_of[m];
                    rsp.found_object = object_of[m];
                    rsp.slot_index   = m[vst_pkg::VST_SLOT_W-1:0];
                end
            end
            default: ;
        endcase
        pending_rsp.push_back(rsp);
    endfunction

    function void match_response(vst_pkg::t_rsp got);
        vst_pkg::t_rsp want;
        if (pending_rsp.size() == 0) begin
            $error("result item arrived with no request waiting");
            errors++;
            return;
        end
        want = pending_rsp.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
        end
        if (got.found_server !== want.found_server) begin
            $error("found_server: expected %h, actual %h",
                   want.found_server, got.found_server);
            errors++;
        end
        if (got.found_object !== want.found_object) begin
            $error("found_object: expected %h, actual %h",
                   want.found_object, got.found_object);
            errors++;
        end
        if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
            errors++;
        end
    endfunction
endclass

module volume_server_table_unit_tb;
    import vst_pkg::*;

    localparam logic [1:0]  OP_NONE      = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned VOL_POOL_N   = 20;
    localparam int unsigned SRV_POOL_N   = 6;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned LONG_HOLD    = 240;
    localparam int unsigned DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    vst_req_if   req_if();
    vst_rsp_if   rsp_if();

    table_shadow shadow = new();
    bit          sender_calm;
    bit          receiver_calm;
    bit          long_hold_req;
    int unsigned idle_cycles;
    logic [31:0] vol_pool[VOL_POOL_N];
    logic [63:0] srv_pool[SRV_POOL_N];

    volume_server_table_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Check results before noting requests taken at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) shadow.match_response(rsp_if.data);
            if (req_if.valid && req_if.ready) shadow.take_request(req_if.data);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_if.valid && req_if.ready) ||
            (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall bursts, one long hold-off on request.
    initial begin
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!receiver_calm && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    task automatic send_item(t_req item);
        req_if.data  <= item;
        req_if.valid <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        if (!sender_calm && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic issue(logic [1:0] op, logic [31:0] vol, logic [31:0] obj,
                         logic [63:0] srv, logic mnt);
        t_req item;
        item.opcode        = op;
        item.vol_key       = vol;
        item.root_obj      = obj;
        item.srv_key       = srv;
        item.still_mounted = mnt;
        send_item(item);
    endtask

    // Mostly pool volumes so that inserts, removes and lookups meet each other.
    task automatic issue_random();
        int unsigned pick;
        logic [31:0] vol;
        logic [63:0] srv;
        logic [63:0] held;
        logic [1:0]  op;
        logic        mnt;
        pick = $urandom_range(0, 99);
        vol  = ($urandom_range(0, 9) == 0) ? $urandom : vol_pool[$urandom_range(0, VOL_POOL_N-1)];
        srv  = ($urandom_range(0, 2) == 0) ? {$urandom, $urandom}
                                           : srv_pool[$urandom_range(0, SRV_POOL_N-1)];
        mnt  = 1'($urandom_range(0, 1));
        if (pick < 35) begin
            op = OP_INSERT;
        end else if (pick < 60) begin
            op  = OP_REMOVE;
            mnt = ($urandom_range(0, 2) == 0);
            if (shadow.stored_server(vol, held) && $urandom_range(0, 3) != 0) srv = held;
        end else if (pick < 95) begin
            op = OP_LOOKUP;
        end else begin
            op = OP_NONE;
        end
        issue(op, vol, $urandom, srv, mnt);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (shadow.outstanding() != 0);
    endtask

    initial begin
        req_if.valid  <= 1'b0;
        req_if.data   <= '0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        long_hold_req = 1'b0;
        vol_pool[0]   = 32'h0000_0000;
        vol_pool[1]   = 32'hFFFF_FFFF;
        // low byte keeps pool entries distinct
        for (int i = 2; i < VOL_POOL_N; i++) vol_pool[i] = ($urandom & 32'hFFFF_FF00) | i;
        srv_pool[0]   = '0;
        srv_pool[1]   = '1;
        for (int i = 2; i < SRV_POOL_N; i++) srv_pool[i] = {$urandom, $urandom};
        do @(posedge i_clk); while (i_rst_n !== 1'b1);

        // empty table: lookup miss, remove of absent volume, no-op opcode
        issue(OP_LOOKUP, vol_pool[0], '1, '1, 1'b1);
        issue(OP_REMOVE, vol_pool[1], '0, '0, 1'b0);
        issue(OP_NONE, '1, '1, '1, 1'b1);
        issue(OP_INSERT, vol_pool[0], '0, '0, 1'b0);
        issue(OP_INSERT, vol_pool[1], '1, '1, 1'b1);
        issue(OP_INSERT, vol_pool[0], '1, '1, 1'b0);
        issue(OP_LOOKUP, vol_pool[1], '0, '0, 1'b0);
        issue(OP_REMOVE, vol_pool[1], '0, '0, 1'b1);
        issue(OP_REMOVE, vol_pool[1], '0, '1, 1'b1);
        issue(OP_REMOVE, vol_pool[1], '0, '1, 1'b0);
        // fill every slot, then overflow
        for (int i = 2; i < 17; i++) begin
            issue(OP_INSERT, vol_pool[i], $urandom, srv_pool[i % SRV_POOL_N], 1'b0);
        end
        issue(OP_INSERT, vol_pool[17], $urandom, srv_pool[2], 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400) long_hold_req = 1'b1;
            if (n == 900) begin
                req_if.valid <= 1'b0;
                wait_drained();
            end
            if (n == RANDOM_ITEMS - 300) begin
                sender_calm   = 1'b1;
                receiver_calm = 1'b1;
            end
            issue_random();
        end

        req_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (shadow.errors == 0 && shadow.outstanding() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
